@@ rtl/core/bmcp_pkg.sv @@
// shared types and constants for the bus mouse counter port
`default_nettype none

package bmcp_pkg;

  localparam int unsigned ACT_W   = 4;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned BTN_W   = 3;
  localparam int unsigned RATE_W  = 2;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned CNTDN_W = PERIOD_W + (1 << RATE_W) - 1;

  // action codes
  localparam logic [ACT_W-1:0] ACT_MOTION  = 4'd0;
  localparam logic [ACT_W-1:0] ACT_PORTA_RD = 4'd1;
  localparam logic [ACT_W-1:0] ACT_PORTB_RD = 4'd2;
  localparam logic [ACT_W-1:0] ACT_PORTC_WR = 4'd3;
  localparam logic [ACT_W-1:0] ACT_PORTC_RD = 4'd4;
  localparam logic [ACT_W-1:0] ACT_CTRL_WR = 4'd5;
  localparam logic [ACT_W-1:0] ACT_RATE_WR = 4'd6;
  localparam logic [ACT_W-1:0] ACT_RATE_RD = 4'd7;
  localparam logic [ACT_W-1:0] ACT_TICK    = 4'd8;

  // fixed port values and masks
  localparam logic [BYTE_W-1:0] PORTB_VALUE   = 8'hFF;
  localparam logic [BYTE_W-1:0] PORTC_RD_SET  = 8'h08;
  localparam logic [BYTE_W-1:0] PORTC_RD_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] PORTC_RESET   = 8'hF0;
  localparam logic [BYTE_W-1:0] RATE_BAD_MASK = 8'hFC;
  localparam logic [BYTE_W-1:0] HELD_RESET    = 8'hFF;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1;

  // port c bit positions
  localparam int unsigned PC_LATCH_BIT = 7;
  localparam int unsigned PC_IRQ_MASK_BIT = 4;
  // control word: bit 7 set means a mode word
  localparam int unsigned CTRL_MODE_BIT = 7;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic signed [BYTE_W-1:0] move_dx;
    logic signed [BYTE_W-1:0] move_dy;
    logic [BTN_W-1:0]  buttons;
    logic [BYTE_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              irq_pulse;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/bmcp_in_stage.sv @@
// input register stage: holds one accepted transaction for processing
`default_nettype none

module bmcp_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire bmcp_pkg::item_t item_i,
  input  wire logic           space_i,
  output logic                step_o,
  output bmcp_pkg::item_t     item_o
);

  logic            valid_r, valid_nxt;
  bmcp_pkg::item_t item_r;

  assign step_o   = valid_r && space_i;
  assign in_ready = !valid_r || space_i;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (step_o) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_i;
    end
  end

  assign item_o = item_r;

endmodule

`default_nettype wire

@@ rtl/core/bmcp_core.sv @@
// mouse state registers and the single-pass update and read logic
`default_nettype none

module bmcp_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              step_i,
  input  wire bmcp_pkg::item_t                   item_i,
  input  wire logic [bmcp_pkg::PERIOD_W-1:0]     base_period_i,
  output bmcp_pkg::result_t                      result_o
);

  logic [bmcp_pkg::BTN_W-1:0]    button_bits_r, button_bits_nxt;
  logic [bmcp_pkg::BYTE_W-1:0]   count_x_r, count_x_nxt;
  logic [bmcp_pkg::BYTE_W-1:0]   count_y_r, count_y_nxt;
  logic [bmcp_pkg::BYTE_W-1:0]   held_x_r, held_x_nxt;
  logic [bmcp_pkg::BYTE_W-1:0]   held_y_r, held_y_nxt;
  logic [bmcp_pkg::RATE_W-1:0]   rate_select_r, rate_select_nxt;
  logic [bmcp_pkg::BYTE_W-1:0]   port_c_r, port_c_nxt;
  logic [bmcp_pkg::CNTDN_W-1:0]  countdown_r, countdown_nxt;

  logic                          pc_store;
  logic [bmcp_pkg::BYTE_W-1:0]   pc_value;
  logic [bmcp_pkg::BYTE_W-1:0]   porta_value;
  logic [bmcp_pkg::BYTE_W-1:0]   nib_src;
  logic [2:0]                    nib_sel;
  logic [2:0]                    ctrl_bit;

  // port a: inverted buttons on top, one nibble picked by port c bits 7..5
  always_comb begin
    nib_sel = port_c_r[7:5];
    case (nib_sel[2:1])
      2'd0:    nib_src = count_x_r;
      2'd1:    nib_src = count_y_r;
      2'd2:    nib_src = held_x_r;
      default: nib_src = held_y_r;
    endcase
    porta_value = {~button_bits_r[0], ~button_bits_r[1], ~button_bits_r[2], 1'b0,
                   nib_sel[0] ? nib_src[7:4] : nib_src[3:0]};
  end

  always_comb begin
    button_bits_nxt = button_bits_r;
    count_x_nxt     = count_x_r;
    count_y_nxt     = count_y_r;
    held_x_nxt      = held_x_r;
    held_y_nxt      = held_y_r;
    rate_select_nxt = rate_select_r;
    port_c_nxt      = port_c_r;
    countdown_nxt   = countdown_r;
    pc_store        = 1'b0;
    pc_value        = port_c_r;
    ctrl_bit        = item_i.write_data[3:1];
    result_o        = '0;

    unique case (item_i.action)
      bmcp_pkg::ACT_MOTION: begin
        button_bits_nxt = item_i.buttons;
        count_x_nxt     = count_x_r + item_i.move_dx;
        count_y_nxt     = count_y_r + item_i.move_dy;
      end
      bmcp_pkg::ACT_PORTA_RD: begin
        result_o.read_data = porta_value;
      end
      bmcp_pkg::ACT_PORTB_RD: begin
        result_o.read_data = bmcp_pkg::PORTB_VALUE;
      end
      bmcp_pkg::ACT_PORTC_WR: begin
        pc_store = 1'b1;
        pc_value = item_i.write_data;
      end
      bmcp_pkg::ACT_PORTC_RD: begin
        result_o.read_data = (port_c_r & bmcp_pkg::PORTC_RD_MASK) | bmcp_pkg::PORTC_RD_SET;
      end
      bmcp_pkg::ACT_CTRL_WR: begin
        // bit set/reset word; mode words are dropped
        if (!item_i.write_data[bmcp_pkg::CTRL_MODE_BIT]) begin
          pc_store           = 1'b1;
          pc_value[ctrl_bit] = item_i.write_data[0];
        end
      end
      bmcp_pkg::ACT_RATE_WR: begin
        if ((item_i.write_data & bmcp_pkg::RATE_BAD_MASK) == '0) begin
          rate_select_nxt = item_i.write_data[bmcp_pkg::RATE_W-1:0];
        end
      end
      bmcp_pkg::ACT_RATE_RD: begin
        result_o.read_data = {{(bmcp_pkg::BYTE_W - bmcp_pkg::RATE_W){1'b0}}, rate_select_r};
      end
      bmcp_pkg::ACT_TICK: begin
        if (countdown_r <= bmcp_pkg::CNTDN_W'(1)) begin
          result_o.irq_pulse = !port_c_r[bmcp_pkg::PC_IRQ_MASK_BIT];
          countdown_nxt = bmcp_pkg::CNTDN_W'(base_period_i) << rate_select_r;
        end else begin
          countdown_nxt = countdown_r - bmcp_pkg::CNTDN_W'(1);
        end
      end
      default: begin
      end
    endcase

    // rising edge on port c bit 7 latches and clears the counters
    if (pc_store) begin
      port_c_nxt = pc_value;
      if (!port_c_r[bmcp_pkg::PC_LATCH_BIT] && pc_value[bmcp_pkg::PC_LATCH_BIT]) begin
        held_x_nxt  = count_x_r;
        held_y_nxt  = count_y_r;
        count_x_nxt = '0;
        count_y_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      button_bits_r <= '0;
      count_x_r     <= '0;
      count_y_r     <= '0;
      held_x_r      <= bmcp_pkg::HELD_RESET;
      held_y_r      <= bmcp_pkg::HELD_RESET;
      rate_select_r <= '0;
      port_c_r      <= bmcp_pkg::PORTC_RESET;
      countdown_r   <= bmcp_pkg::CNTDN_W'(bmcp_pkg::PERIOD_RESET);
    end else if (step_i) begin
      button_bits_r <= button_bits_nxt;
      count_x_r     <= count_x_nxt;
      count_y_r     <= count_y_nxt;
      held_x_r      <= held_x_nxt;
      held_y_r      <= held_y_nxt;
      rate_select_r <= rate_select_nxt;
      port_c_r      <= port_c_nxt;
      countdown_r   <= countdown_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bmcp_out_stage.sv @@
// result register: holds one finished transaction until the receiver takes it
`default_nettype none

module bmcp_out_stage (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         load_i,
  input  wire bmcp_pkg::result_t result_i,
  output logic              space_o,
  output logic              out_valid,
  input  wire logic         out_ready,
  output bmcp_pkg::result_t result_o
);

  logic              valid_r, valid_nxt;
  bmcp_pkg::result_t result_r;

  assign space_o = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load_i) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      result_r <= result_i;
    end
  end

  assign out_valid = valid_r;
  assign result_o  = result_r;

endmodule

`default_nettype wire

@@ rtl/core/bus_mouse_counter_port.sv @@
// top level of the bus mouse counter port
//
// usage:
//   in_* channel carries one transaction per action: motion, port a/b/c
//   accesses, control word, rate select, or a time tick. every accepted
//   transaction gives exactly one result transaction on out_* (read_data for
//   reads, zero otherwise; irq_pulse on an expiring tick if port c bit 4 is 0).
//   cfg_* channel writes base_period, the tick count of one 120 Hz period;
//   write it only while no transaction is in flight. cfg_ready is always high.
// path: an accepted transaction waits in the input register; its result is
//   loaded into the result register when the input register advances.
// throughput: one transaction per cycle while out_ready stays high. the rate
//   is set by the input register and the result register, with one pass of
//   update logic between them.
// reset: synchronous, active low. both stages empty, counters zero, hold
//   latches 0xff, port c 0xf0, rate 0, base_period 1, countdown 1.
// stall: when out_ready is low the result register holds; the input
//   register still takes one more transaction, then in_ready drops until
//   the receiver takes the waiting result.
`default_nettype none

module bus_mouse_counter_port (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input transactions
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [bmcp_pkg::ACT_W-1:0]      in_action,
  input  wire logic signed [bmcp_pkg::BYTE_W-1:0] in_move_dx,
  input  wire logic signed [bmcp_pkg::BYTE_W-1:0] in_move_dy,
  input  wire logic [bmcp_pkg::BTN_W-1:0]      in_buttons,
  input  wire logic [bmcp_pkg::BYTE_W-1:0]     in_write_data,
  // result transactions
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [bmcp_pkg::BYTE_W-1:0]          out_read_data,
  output logic                                 out_irq_pulse,
  // configuration write
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bmcp_pkg::PERIOD_W-1:0]   cfg_data
);

  bmcp_pkg::item_t   in_item;
  bmcp_pkg::item_t   work_item;
  bmcp_pkg::result_t core_result;
  bmcp_pkg::result_t out_result;
  logic              step;
  logic              out_space;

  logic [bmcp_pkg::PERIOD_W-1:0] base_period_r;

  // pack the input fields into one transaction
  assign in_item.action     = in_action;
  assign in_item.move_dx    = in_move_dx;
  assign in_item.move_dy    = in_move_dy;
  assign in_item.buttons    = in_buttons;
  assign in_item.write_data = in_write_data;

  // config register: always ready, takes effect at the next countdown reload
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_period_r <= bmcp_pkg::PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      base_period_r <= cfg_data;
    end
  end

  // input register; it advances whenever the result register has room
  bmcp_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .item_i   (in_item),
    .space_i  (out_space),
    .step_o   (step),
    .item_o   (work_item)
  );

  // mouse state and the per-transaction update
  bmcp_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_i        (step),
    .item_i        (work_item),
    .base_period_i (base_period_r),
    .result_o      (core_result)
  );

  // result register, loaded in the same cycle the state updates
  bmcp_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (step),
    .result_i  (core_result),
    .space_o   (out_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result_o  (out_result)
  );

  assign out_read_data = out_result.read_data;
  assign out_irq_pulse = out_result.irq_pulse;

endmodule

`default_nettype wire

@@ rtl/core/bmcp_checker.sv @@
// port-level checks for the bus mouse counter port, bound to the top level
`default_nettype none

module bmcp_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [bmcp_pkg::BYTE_W-1:0]   out_read_data,
  input wire logic                          out_irq_pulse,
  input wire logic                          cfg_ready
);

  // nothing is left in flight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) && $stable(out_irq_pulse))
    else $error("stalled result changed");

  // only a tick raises the interrupt, and a tick returns no read byte
  a_irq_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_irq_pulse |-> out_read_data == '0)
    else $error("interrupt result carries read data");

  // after acceptance a result is waiting, its own or an older stalled one
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> ##1 out_valid)
    else $error("accepted transaction gave no result");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port not ready");

endmodule

bind bus_mouse_counter_port bmcp_checker u_bmcp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_read_data (out_read_data),
  .out_irq_pulse (out_irq_pulse),
  .cfg_ready     (cfg_ready)
);

`default_nettype wire
